[src/lsrs_pkg.sv]
`timescale 1ns / 1ps
package lsrs_pkg;
    localparam int StackDepthDefault = 8;
    localparam int MaxResults = 8;

    localparam logic [2:0] REQ_PUSH      = 3'd0;
    localparam logic [2:0] REQ_POP       = 3'd1;
    localparam logic [2:0] REQ_RESUME    = 3'd2;
    localparam logic [2:0] REQ_READ      = 3'd3;
    localparam logic [2:0] REQ_SNAP      = 3'd4;
    localparam logic [2:0] REQ_STAT      = 3'd5;
    localparam logic [2:0] REQ_CLEAR     = 3'd6;
    localparam logic [2:0] REQ_CLEAR_ALT = 3'd7;

    // Statistic selectors below SEL_DEEPEST pick an event counter.
    localparam logic [2:0] SEL_DEEPEST = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] LIFE_INIT      = 2'd0;
    localparam logic [1:0] LIFE_RESUMED   = 2'd1;
    localparam logic [1:0] LIFE_PAUSED    = 2'd2;
    localparam logic [1:0] LIFE_DESTROYED = 2'd3;

    localparam int EvLaunch  = 0;
    localparam int EvExit    = 1;
    localparam int EvResume  = 2;
    localparam int EvPause   = 3;
    localparam int EvDestroy = 4;
    localparam int EvDrop    = 5;

    typedef struct packed {
        logic [2:0]  req;
        logic [31:0] owner;
        logic [31:0] process;
        logic [5:0]  idx;
        logic [6:0]  want;
        logic [2:0]  sel;
    } t_req;
endpackage

[src/lsrs_front.sv]
`timescale 1ns / 1ps
// Two-entry request queue between the input channel and the execution engine.
module lsrs_front
    import lsrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_take,
    output t_req o_req
);
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[src/lsrs_back.sv]
`timescale 1ns / 1ps
// Executes one request at a time; a snapshot scans one slot per cycle.
module lsrs_back
    import lsrs_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_take,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot_position,
    output logic [31:0] o_owner_out,
    output logic [31:0] o_process_out,
    output logic [1:0]  o_life_state,
    output logic [31:0] o_launch_seq,
    output logic [6:0]  o_depth_now,
    output logic [31:0] o_stat_value,
    output logic        o_last
);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DFULL = DW'(STACK_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT, S_OUT} t_state;

    logic [31:0]        r_owner [STACK_DEPTH];
    logic [31:0]        r_proc  [STACK_DEPTH];
    logic [1:0]         r_life  [STACK_DEPTH];
    logic [31:0]        r_seq   [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_taken;
    logic [DW-1:0]      r_depth, r_deep;
    logic [31:0]        r_ctr, r_ev [6];
    t_state             r_state;
    logic [IW-1:0]      r_i, r_best;
    logic               r_found;
    logic [6:0]         r_limit, r_k;
    logic               r_ov;

    logic [IW-1:0] w_top, w_below, w_idx;
    logic [31:0]   w_ctr1;
    logic          w_better;

    assign o_valid = r_ov;
    assign o_take  = (r_state == S_IDLE) && !r_ov;
    assign w_top   = IW'(r_depth - DW'(1));
    assign w_below = IW'(r_depth - DW'(2));
    assign w_idx   = IW'(i_req.idx);
    assign w_ctr1  = r_ctr + 32'd1;
    assign w_better = !r_taken[r_i] && (!r_found || r_seq[r_i] > r_seq[r_best]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_depth <= '0;
            r_deep <= '0;
            r_ctr <= '0;
            for (int j = 0; j < 6; j++) r_ev[j] <= '0;
            for (int j = 0; j < STACK_DEPTH; j++) begin
                r_life[j] <= LIFE_INIT;
                r_seq[j] <= '0;
            end
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        o_status <= ST_OK;
                        o_slot_position <= '0;
                        o_owner_out <= '0;
                        o_process_out <= '0;
                        o_life_state <= LIFE_INIT;
                        o_launch_seq <= '0;
                        o_stat_value <= '0;
                        o_last <= 1'b1;
                        o_depth_now <= 7'(r_depth);
                        r_ov <= 1'b1;
                        case (i_req.req)
                            REQ_PUSH: begin
                                if (r_depth == DFULL) begin
                                    r_ev[EvDrop] <= r_ev[EvDrop] + 32'd1;
                                    o_status <= ST_FULL;
                                end else begin
                                    if (r_depth != '0 && r_life[w_top] == LIFE_RESUMED) begin
                                        r_life[w_top] <= LIFE_PAUSED;
                                        r_ev[EvPause] <= r_ev[EvPause] + 32'd1;
                                    end
                                    r_owner[IW'(r_depth)] <= i_req.owner;
                                    r_proc[IW'(r_depth)] <= i_req.process;
                                    r_life[IW'(r_depth)] <= LIFE_INIT;
                                    r_seq[IW'(r_depth)] <= w_ctr1;
                                    r_ctr <= w_ctr1;
                                    r_depth <= r_depth + DW'(1);
                                    if (r_depth + DW'(1) > r_deep) r_deep <= r_depth + DW'(1);
                                    r_ev[EvLaunch] <= r_ev[EvLaunch] + 32'd1;
                                    o_slot_position <= 6'(r_depth);
                                    o_owner_out <= i_req.owner;
                                    o_process_out <= i_req.process;
                                    o_launch_seq <= w_ctr1;
                                    o_depth_now <= 7'(r_depth + DW'(1));
                                end
                            end
                            REQ_POP: begin
                                if (r_depth == '0) begin
                                    o_status <= ST_EMPTY;
                                end else begin
                                    if (r_life[w_top] != LIFE_DESTROYED)
                                        r_ev[EvDestroy] <= r_ev[EvDestroy] + 32'd1;
                                    r_life[w_top] <= LIFE_DESTROYED;
                                    r_depth <= r_depth - DW'(1);
                                    r_ev[EvExit] <= r_ev[EvExit] + 32'd1;
                                    o_slot_position <= 6'(w_top);
                                    o_owner_out <= r_owner[w_top];
                                    o_process_out <= r_proc[w_top];
                                    o_life_state <= LIFE_DESTROYED;
                                    o_launch_seq <= r_seq[w_top];
                                    o_depth_now <= 7'(r_depth - DW'(1));
                                    if (r_depth > DW'(1)) begin
                                        if (r_life[w_below] != LIFE_RESUMED)
                                            r_ev[EvResume] <= r_ev[EvResume] + 32'd1;
                                        r_life[w_below] <= LIFE_RESUMED;
                                        r_seq[w_below] <= w_ctr1;
                                        r_ctr <= w_ctr1;
                                    end
                                end
                            end
                            REQ_RESUME: begin
                                if (r_depth == '0) begin
                                    o_status <= ST_EMPTY;
                                end else begin
                                    if (r_life[w_top] != LIFE_RESUMED)
                                        r_ev[EvResume] <= r_ev[EvResume] + 32'd1;
                                    r_life[w_top] <= LIFE_RESUMED;
                                    r_seq[w_top] <= w_ctr1;
                                    r_ctr <= w_ctr1;
                                    o_slot_position <= 6'(w_top);
                                    o_owner_out <= r_owner[w_top];
                                    o_process_out <= r_proc[w_top];
                                    o_life_state <= LIFE_RESUMED;
                                    o_launch_seq <= w_ctr1;
                                end
                            end
                            REQ_READ: begin
                                if (7'(i_req.idx) >= 7'(r_depth)) begin
                                    o_status <= ST_RANGE;
                                end else begin
                                    o_slot_position <= i_req.idx;
                                    o_owner_out <= r_owner[w_idx];
                                    o_process_out <= r_proc[w_idx];
                                    o_life_state <= r_life[w_idx];
                                    o_launch_seq <= r_seq[w_idx];
                                end
                            end
                            REQ_SNAP: begin
                                if (i_req.want == '0 || r_depth == '0) begin
                                    o_status <= ST_EMPTY;
                                end else begin
                                    r_ov <= 1'b0;
                                    r_limit <= (i_req.want < 7'(r_depth)) ? i_req.want
                                                                         : 7'(r_depth);
                                    if (i_req.want > 7'(MaxResults) && r_depth > DW'(MaxResults))
                                        r_limit <= 7'(MaxResults);
                                    else if (i_req.want >= 7'(r_depth) && r_depth > DW'(MaxResults))
                                        r_limit <= 7'(MaxResults);
                                    r_k <= '0;
                                    r_taken <= '0;
                                    r_i <= '0;
                                    r_found <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_STAT: begin
                                if (i_req.sel < SEL_DEEPEST) o_stat_value <= r_ev[i_req.sel];
                                else if (i_req.sel == SEL_DEEPEST) o_stat_value <= 32'(r_deep);
                                else o_status <= ST_RANGE;
                            end
                            default: begin
                                r_depth <= '0;
                                r_deep <= '0;
                                r_ctr <= '0;
                                for (int j = 0; j < 6; j++) r_ev[j] <= '0;
                                for (int j = 0; j < STACK_DEPTH; j++) begin
                                    r_life[j] <= LIFE_INIT;
                                    r_seq[j] <= '0;
                                end
                                o_depth_now <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_better) begin
                        r_best <= r_i;
                        r_found <= 1'b1;
                    end
                    if (DW'(r_i) == r_depth - DW'(1)) r_state <= S_EMIT;
                    else r_i <= r_i + IW'(1);
                end
                S_EMIT: begin
                    if (!r_ov) begin
                        r_taken[r_best] <= 1'b1;
                        o_status <= ST_OK;
                        o_slot_position <= 6'(r_best);
                        o_owner_out <= r_owner[r_best];
                        o_process_out <= r_proc[r_best];
                        o_life_state <= r_life[r_best];
                        o_launch_seq <= r_seq[r_best];
                        o_depth_now <= 7'(r_depth);
                        o_stat_value <= '0;
                        o_last <= (r_k + 7'd1 == r_limit);
                        r_ov <= 1'b1;
                        r_k <= r_k + 7'd1;
                        r_i <= '0;
                        r_found <= 1'b0;
                        r_state <= (r_k + 7'd1 == r_limit) ? S_OUT : S_SCAN;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[src/lifecycle_stack_with_recency_snapshot.sv]
`timescale 1ns / 1ps
// Bounded lifecycle stack with an MRU-first snapshot readout. A request is
// queued in a two-entry front queue and executed one at a time by the back end.
// Push, pop, resume, slot read, statistic read and clear each return one beat
// that is valid the cycle after the back end takes the request. The back end
// takes the next request only once the previous beat has left. A snapshot of n
// entries returns n beats, n being the requested count capped at the live depth
// and at MaxResults, and each beat costs one scan over the live slots followed
// by an emit step. No clearing pass follows reset.
module lifecycle_stack_with_recency_snapshot
    import lsrs_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_owner_id,
    input  logic [31:0] i_process_id,
    input  logic [5:0]  i_slot_index,
    input  logic [6:0]  i_snap_count,
    input  logic [2:0]  i_stat_select,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot_position,
    output logic [31:0] o_owner_out,
    output logic [31:0] o_process_out,
    output logic [1:0]  o_life_state,
    output logic [31:0] o_launch_seq,
    output logic [6:0]  o_depth_now,
    output logic [31:0] o_stat_value,
    output logic        o_last
);
    t_req w_in, w_q;
    logic w_qv, w_take;

    assign w_in = '{req: i_req_type, owner: i_owner_id, process: i_process_id,
                    idx: i_slot_index, want: i_snap_count, sel: i_stat_select};

    lsrs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(w_in), .o_valid(w_qv), .i_take(w_take), .o_req(w_q)
    );

    lsrs_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_take(w_take),
        .i_req(w_q), .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_slot_position(o_slot_position), .o_owner_out(o_owner_out),
        .o_process_out(o_process_out), .o_life_state(o_life_state),
        .o_launch_seq(o_launch_seq), .o_depth_now(o_depth_now),
        .o_stat_value(o_stat_value), .o_last(o_last)
    );
endmodule
